// File: hdl/ste_pkg.sv
// ============================================================================
// ste_pkg: shared constants, types and quarter-wave table for the sine tone
// generator. The table is computed at elaboration in 62-bit fixed point.
// ============================================================================
`default_nettype none

package ste_pkg;

  // Widths of the phase path, the table index and the sample.
  localparam int PHASE_BITS       = 32;
  localparam int TABLE_INDEX_BITS = 12;
  localparam int SAMPLE_BITS      = 16;

  localparam int QUARTER_BITS = TABLE_INDEX_BITS - 2;
  localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
  localparam int MAG_BITS     = SAMPLE_BITS - 1;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = PHASE_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_OFFSET = CFG_INDEX_BITS'(1);

  // Peak magnitude, 2^(SAMPLE_BITS-1)-1.
  localparam logic [MAG_BITS-1:0] AMPLITUDE = {MAG_BITS{1'b1}};

  // Most negative sample code, which the generator never produces.
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Side information that travels with a table read.
  typedef struct packed {
    logic negate;
    logic peak;
    logic last;
  } ste_tag_t;

  typedef logic [MAG_BITS-1:0] ste_rom_t [QUARTER_SIZE];

  // Constants for the table computation.
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [9:0]  SINE_DIV [13] = '{10'd6, 10'd20, 10'd42, 10'd72, 10'd110,
                                            10'd156, 10'd210, 10'd272, 10'd342,
                                            10'd420, 10'd506, 10'd600, 10'd702};

  // (a*b) >> 62, truncated to 64 bits.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Truncated quotient of a by a small divisor, by restoring long division.
  // The remainder stays below the divisor, so eleven bits hold it.
  function automatic logic [63:0] div_small(input logic [63:0] a, input logic [9:0] d);
    logic [63:0] q;
    logic [10:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[9:0], a[6'(i)]};
      if (rem >= {1'b0, d}) begin
        rem        = rem - {1'b0, d};
        q[6'(i)]   = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series of sin(x), x in Q62, odd terms up to x^27.
  function automatic logic [63:0] sine_q62(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 13; n++) begin
      term = div_small(mul_q62(term, x2), SINE_DIV[4'(n-1)]);
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Quarter-wave table: round(A*sin(pi/2*k/Q)), rounded half up.
  function automatic ste_rom_t build_rom();
    ste_rom_t    rom;
    logic [63:0] x;
    logic [63:0] s40;
    logic [63:0] v;
    logic [63:0] k64;
    for (int k = 0; k < QUARTER_SIZE; k++) begin
      k64    = 64'(k);
      x      = (HALF_PI_Q62 >> QUARTER_BITS) * k64
             + (((HALF_PI_Q62 & 64'(QUARTER_SIZE - 1)) * k64) >> QUARTER_BITS);
      s40    = sine_q62(x) >> 22;
      v      = s40 * 64'(AMPLITUDE);
      v      = (v + (64'd1 << 39)) >> 40;
      rom[QUARTER_BITS'(k)] = v[MAG_BITS-1:0];
    end
    return rom;
  endfunction

  localparam ste_rom_t QUARTER_ROM = build_rom();

endpackage

`default_nettype wire

// File: hdl/ste_quarter_rom.sv
// ============================================================================
// ste_quarter_rom: quarter-wave sine table with a registered read port.
// One read per cycle; the data is registered and valid in the cycle after the enabled read.
// ============================================================================
`default_nettype none

module ste_quarter_rom (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [ste_pkg::QUARTER_BITS-1:0] rd_addr,
  output logic      [ste_pkg::MAG_BITS-1:0]     rd_data
);
  import ste_pkg::*;

  logic [MAG_BITS-1:0] rd_data_r;

  // Synchronous read; the data register holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= QUARTER_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/ste_phase_acc.sv
// ============================================================================
// ste_phase_acc: configuration registers, phase accumulator and table
// address generation with quadrant folding.
// ============================================================================
`default_nettype none

module ste_phase_acc (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ste_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [ste_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  wire logic                              advance,
  input  wire logic                              restart,
  input  wire logic                              end_of_block,
  output logic      [ste_pkg::QUARTER_BITS-1:0]   rom_addr,
  output ste_pkg::ste_tag_t                      tag
);
  import ste_pkg::*;

  logic [PHASE_BITS-1:0]       step_r;
  logic [PHASE_BITS-1:0]       offset_r;
  logic [PHASE_BITS-1:0]       acc_r;
  logic [PHASE_BITS-1:0]       acc_nxt;
  logic [PHASE_BITS-1:0]       acc_used;
  logic [PHASE_BITS-1:0]       phase;
  logic [TABLE_INDEX_BITS-1:0] p;
  logic [1:0]                  quadrant;
  logic [QUARTER_BITS-1:0]     r;
  ste_tag_t                    tag_r;
  ste_tag_t                    tag_nxt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      offset_r <= '0;
    end else if (cfg_we) begin
      priority if (cfg_index == REG_PHASE_STEP) begin
        step_r <= cfg_wdata[PHASE_BITS-1:0];
      end else if (cfg_index == REG_PHASE_OFFSET) begin
        offset_r <= cfg_wdata[PHASE_BITS-1:0];
      end
    end
  end

  // Phase of this item and the accumulator after it.
  always_comb begin
    acc_used = restart ? '0 : acc_r;
    phase    = offset_r + acc_used;
    acc_nxt  = acc_used + step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (advance) begin
      acc_r <= acc_nxt;
    end
  end

  // Quadrant folding: odd quadrants mirror the table, the upper half negates.
  // A mirrored read at the start of an odd quadrant lands past the table and
  // takes the peak value instead.
  always_comb begin
    p                = phase[PHASE_BITS-1 -: TABLE_INDEX_BITS];
    quadrant         = p[TABLE_INDEX_BITS-1 -: 2];
    r                = p[QUARTER_BITS-1:0];
    tag_nxt.negate   = quadrant[1];
    tag_nxt.last     = end_of_block;
    if (quadrant[0]) begin
      rom_addr       = QUARTER_BITS'(~r + 1'b1);
      tag_nxt.peak   = (r == '0);
    end else begin
      rom_addr       = r;
      tag_nxt.peak   = 1'b0;
    end
  end

  // The tag is captured alongside the table read.
  always_ff @(posedge clk) begin
    if (advance) begin
      tag_r <= tag_nxt;
    end
  end

  assign tag = tag_r;

endmodule

`default_nettype wire

// File: hdl/sine_tone_generator.sv
// ============================================================================
// sine_tone_generator: direct digital synthesis sine source.
// Each input item yields one Q1.15 sine sample from a quarter-wave table.
// ============================================================================
// The block takes one item per clock unless the input stalls and returns one
// sample per item: the table stage adds the phase offset to the accumulator
// and reads the 1024-entry quarter-wave table, the output stage substitutes
// the peak and signs the value into the output register. Throughput is one
// item per cycle while the output side accepts samples. The table stage keeps
// filling while a sample waits at the output, so input stalls only when both
// stages are full. The user must write phase step and phase offset through the
// cfg_ port only while no item is in flight; the block does not enforce this.
// An item with restart set clears the accumulator before its own sample.
`default_nettype none

module sine_tone_generator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [ste_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [ste_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_restart,
  input  wire logic                               in_end_of_block,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [ste_pkg::SAMPLE_BITS-1:0]  out_sample,
  output logic                                    out_last
);
  import ste_pkg::*;

  logic                          accept;
  logic [QUARTER_BITS-1:0]       rom_addr;
  logic [MAG_BITS-1:0]           rom_data;
  ste_tag_t                      tag;
  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          load_out;
  logic [MAG_BITS-1:0]           mag;
  logic signed [SAMPLE_BITS-1:0] sample_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_last_r;

  // Handshake: the table stage advances when empty or when it drains.
  always_comb begin
    load_out      = s1_valid_r && (!out_valid_r || out_ready);
    in_ready      = !s1_valid_r || load_out;
    accept        = in_valid && in_ready;
    s1_valid_nxt  = accept || (s1_valid_r && !load_out);
    out_valid_nxt = load_out || (out_valid_r && !out_ready);
  end

  ste_phase_acc u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .advance      (accept),
    .restart      (in_restart),
    .end_of_block (in_end_of_block),
    .rom_addr     (rom_addr),
    .tag          (tag)
  );

  ste_quarter_rom u_rom (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // Valid flags of the two stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Peak substitution and sign of the sample.
  always_comb begin
    mag = tag.peak ? AMPLITUDE : rom_data;
    if (tag.negate) begin
      sample_nxt = -$signed({1'b0, mag});
    end else begin
      sample_nxt = $signed({1'b0, mag});
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= sample_nxt;
      out_last_r   <= tag.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

  // Input stalls only when both stages hold an item and the output is blocked.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while a stage had room");

  // An accepted item always occupies the table stage next cycle.
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted item lost before the table stage");

  // The symmetric range never reaches the most negative code.
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample != SAMPLE_MIN))
    else $error("sample outside the symmetric range");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ============================================================================
// Sine tone generator testbench
// Drives ticks through the valid/ready input channel and checks every sample
// and end flag against a phase accumulator and quarter-wave table model that
// lives in the bench. Phase step and offset change between segments once all
// samples are back. Both sides idle at random, and the output side holds off
// once for a long stretch so that the generator fills up and stalls.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;

  localparam int SW          = ste_pkg::SAMPLE_BITS;
  localparam int QUARTER     = 1024;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 64;
  localparam logic [63:0] HALF_PI_FIX = 64'h6487ED5110B4611A;
  localparam logic [14:0] PEAK        = 15'h7FFF;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 last;
  } tone_t;

  // Tone model: phase accumulator, registers and the expected samples in order.
  class tone_scoreboard;
    logic [31:0] step_reg;
    logic [31:0] offset_reg;
    logic [31:0] phase_acc;
    logic [14:0] quarter_wave [QUARTER];
    tone_t       tone_q [$];
    int          errors;

    // Fill the quarter-wave table with a fixed-point Taylor series of sin.
    function new();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      step_reg   = '0;
      offset_reg = '0;
      phase_acc  = '0;
      errors     = 0;
      for (int k = 0; k < QUARTER; k++) begin
        x = (HALF_PI_FIX >> 10) * 64'(k) + (((HALF_PI_FIX & 64'd1023) * 64'(k)) >> 10);
        x2   = q62_mul(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 13; n++) begin
          term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        v = (sum >> 22) * 64'(PEAK);
        v = (v + (64'd1 << 39)) >> 40;
        quarter_wave[10'(k)] = v[14:0];
      end
    endfunction

    // Product of two Q62 numbers, kept to 64 bits.
    function logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return 64'(wide >> 62);
    endfunction

    function void set_reg(logic [ste_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] value);
      if (idx == ste_pkg::REG_PHASE_STEP) begin
        step_reg = value;
      end else if (idx == ste_pkg::REG_PHASE_OFFSET) begin
        offset_reg = value;
      end
    endfunction

    // An accepted tick: form its sample, then advance the accumulator.
    function void note_tick(logic restart, logic end_of_block);
      logic [31:0]          phase;
      logic [11:0]          idx;
      logic [9:0]           r;
      logic [14:0]          mag;
      logic signed [SW-1:0] value;
      tone_t                t;
      if (restart) begin
        phase_acc = '0;
      end
      phase = offset_reg + phase_acc;
      idx   = phase[31:20];
      r     = idx[9:0];
      // Odd quadrants run the table backward; at their start the peak is used.
      if (idx[10]) begin
        mag = (r == 0) ? PEAK : quarter_wave[10'(QUARTER - int'(r))];
      end else begin
        mag = quarter_wave[r];
      end
      value = {1'b0, mag};
      if (idx[11]) begin
        value = -value;
      end
      t.sample = value;
      t.last   = end_of_block;
      tone_q.push_back(t);
      phase_acc = phase_acc + step_reg;
    endfunction

    function void check_sample(logic signed [SW-1:0] sample, logic last);
      tone_t t;
      if (tone_q.size() == 0) begin
        $error("unexpected item: sample %0d last %0b", sample, last);
        errors++;
        return;
      end
      t = tone_q.pop_front();
      if (sample !== t.sample) begin
        $error("sample mismatch: expected %0d, actual %0d", t.sample, sample);
        errors++;
      end
      if (last !== t.last) begin
        $error("last mismatch: expected %0b, actual %0b", t.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [ste_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [ste_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               in_restart = 1'b0;
  logic                               in_end_of_block = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [SW-1:0]               out_sample;
  logic                               out_last;

  tone_scoreboard sb;
  int             in_idle_pct = 23;
  int             out_idle_pct = 83;
  bit             backlog_armed = 1'b0;
  int             cycle_count = 0;

  sine_tone_generator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .in_end_of_block (in_end_of_block),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_last        (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off once armed.
  initial begin : receiver
    int  hold_left;
    bit  backlog_done;
    hold_left    = 0;
    backlog_done = 1'b0;
    forever begin
      @(posedge clk);
      if (backlog_armed && !backlog_done) begin
        backlog_done = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Check each sample as it leaves the generator.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_sample(out_sample, out_last);
    end
  end

  // Offer one tick, after a random gap, and wait for it to be taken.
  task automatic send_tick(input logic restart, input logic end_of_block);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_restart      <= restart;
    in_end_of_block <= end_of_block;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sb.note_tick(restart, end_of_block);
  endtask

  // Stop offering and wait until every sample is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.tone_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] step, input logic [31:0] offset);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= ste_pkg::REG_PHASE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    sb.set_reg(ste_pkg::REG_PHASE_STEP, step);
    cfg_index <= ste_pkg::REG_PHASE_OFFSET;
    cfg_wdata <= offset;
    @(posedge clk);
    sb.set_reg(ste_pkg::REG_PHASE_OFFSET, offset);
    cfg_we <= 1'b0;
  endtask

  // Slow tones, arbitrary steps, the ends of the range and whole table-entry steps.
  function automatic logic [31:0] pick_step();
    unique case ($urandom_range(3))
      0: return $urandom_range(32'h0040_0000);
      1: return $urandom_range(32'h8000_0000);
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h0;
      default: return 32'($urandom_range(2048)) << 20;
    endcase
  endfunction

  // Blocks that start with restart and end with the end flag, some noise.
  task automatic send_blocks(input int count);
    int  sent;
    int  len;
    bit  noise;
    sent = 0;
    while (sent < count) begin
      len   = $urandom_range(40, 1);
      noise = ($urandom_range(99) < 15);
      for (int k = 0; k < len && sent < count; k++) begin
        if (noise) begin
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          send_tick(k == 0, k == len - 1);
        end
        sent++;
      end
    end
  endtask

  task automatic random_phase(input int in_pct, input int out_pct, input bit backlog);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int seg = 0; seg < 4; seg++) begin
      write_regs(pick_step(), $urandom());
      if (backlog && seg == 1) begin
        backlog_armed = 1'b1;
      end
      send_blocks(107);
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values: a flat tone at zero phase.
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);

    // Quarter-turn step: zero, positive peak, zero, negative peak.
    write_regs(32'h4000_0000, 32'h0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);

    // Half-turn step and largest offset: the phase sum and accumulator wrap.
    write_regs(32'h8000_0000, 32'hFFFF_FFFF);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);

    // One table entry per tick across the first quarter boundary.
    write_regs(32'h0010_0000, 32'h3FE0_0000);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);

    random_phase(23, 83, 1'b0);
    random_phase(83, 23, 1'b0);
    random_phase(0, 0, 1'b1);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
